FILE: sv/fpavt_pkg.sv
// Package for the fixed-point affine vector transform.
// Holds widths, register indexes, reset values and the stage enable type.
// No dependencies.
`default_nettype none

package fpavt_pkg;

  localparam int COORD_W   = 16;
  localparam int ENTRY_W   = 16;
  localparam int ROW_W     = 3 * ENTRY_W;
  localparam int PROD_W    = COORD_W + ENTRY_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int RES_W     = 32;
  localparam int NUM_LANES = 3;
  localparam int NUM_COLS  = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = ROW_W;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_Z = 3'd5;

  localparam logic [ROW_W-1:0] ROW_0_RST = 48'h0000_0000_1000;
  localparam logic [ROW_W-1:0] ROW_1_RST = 48'h0000_1000_0000;
  localparam logic [ROW_W-1:0] ROW_2_RST = 48'h1000_0000_0000;
  localparam logic [RES_W-1:0] TRANS_RST = 32'h0000_0000;

  typedef logic [ROW_W-1:0] row_t;
  typedef logic [RES_W-1:0] res_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

`default_nettype wire

FILE: sv/fpavt_if.sv
// Valid/ready channel interfaces for vertex beats and result beats.
// Depends on fpavt_pkg for field widths.
`default_nettype none

interface fpavt_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [fpavt_pkg::COORD_W-1:0]     in_x;
  logic signed [fpavt_pkg::COORD_W-1:0]     in_y;
  logic signed [fpavt_pkg::COORD_W-1:0]     in_z;

  modport source (output valid, output in_x, output in_y, output in_z, input ready);
  modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

interface fpavt_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [fpavt_pkg::RES_W-1:0]       out_x;
  logic signed [fpavt_pkg::RES_W-1:0]       out_y;
  logic signed [fpavt_pkg::RES_W-1:0]       out_z;

  modport source (output valid, output out_x, output out_y, output out_z, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z, output ready);
endinterface

`default_nettype wire

FILE: sv/fpavt_lane.sv
// One matrix row lane: three products, row sum, truncating scale by 2^FRAC_BITS.
// Depends on fpavt_pkg; stage enables come from the top level.
`default_nettype none

module fpavt_lane #(
  parameter int FRAC_BITS = 12
) (
  input  wire                                  clk,
  input  wire fpavt_pkg::stage_en_t            en,
  input  wire logic signed [fpavt_pkg::COORD_W-1:0] x,
  input  wire logic signed [fpavt_pkg::COORD_W-1:0] y,
  input  wire logic signed [fpavt_pkg::COORD_W-1:0] z,
  input  wire fpavt_pkg::row_t                 row,
  output fpavt_pkg::res_t                      q
);

  localparam logic [fpavt_pkg::SUM_W-1:0] BIAS =
    fpavt_pkg::SUM_W'((64'd1 << FRAC_BITS) - 64'd1);

  logic signed [fpavt_pkg::ENTRY_W-1:0] e0, e1, e2;
  logic signed [fpavt_pkg::PROD_W-1:0]  p0_r, p1_r, p2_r;
  logic signed [fpavt_pkg::PROD_W-1:0]  p0_nxt, p1_nxt, p2_nxt;
  logic signed [fpavt_pkg::SUM_W-1:0]   sum_r, sum_nxt;
  logic signed [fpavt_pkg::SUM_W-1:0]   biased, shifted;
  fpavt_pkg::res_t                      q_r, q_nxt;

  always_comb begin
    e0     = row[fpavt_pkg::ENTRY_W-1:0];
    e1     = row[2*fpavt_pkg::ENTRY_W-1:fpavt_pkg::ENTRY_W];
    e2     = row[3*fpavt_pkg::ENTRY_W-1:2*fpavt_pkg::ENTRY_W];
    p0_nxt = x * e0;
    p1_nxt = y * e1;
    p2_nxt = z * e2;
    sum_nxt = p0_r + p1_r + p2_r;
    // round toward zero: bias negative sums before the arithmetic shift
    biased  = sum_r + (sum_r[fpavt_pkg::SUM_W-1] ? $signed(BIAS) : '0);
    shifted = biased >>> FRAC_BITS;
    q_nxt   = shifted[fpavt_pkg::RES_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      p0_r <= p0_nxt;
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
    end
    if (en.s2) begin
      sum_r <= sum_nxt;
    end
    if (en.s3) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

FILE: sv/fpavt_merge.sv
// Output stage: adds each lane's translation and registers the result beat.
// Depends on fpavt_pkg; fed by the three fpavt_lane instances.
`default_nettype none

module fpavt_merge (
  input  wire                                              clk,
  input  wire fpavt_pkg::stage_en_t                        en,
  input  wire logic [fpavt_pkg::NUM_LANES-1:0][fpavt_pkg::RES_W-1:0] lane_q,
  input  wire logic [fpavt_pkg::NUM_LANES-1:0][fpavt_pkg::RES_W-1:0] trans,
  output fpavt_pkg::res_t                                  res_x,
  output fpavt_pkg::res_t                                  res_y,
  output fpavt_pkg::res_t                                  res_z
);

  fpavt_pkg::res_t x_r, y_r, z_r;
  fpavt_pkg::res_t x_nxt, y_nxt, z_nxt;

  always_comb begin
    x_nxt = lane_q[0] + trans[0];
    y_nxt = lane_q[1] + trans[1];
    z_nxt = lane_q[2] + trans[2];
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign res_x = x_r;
  assign res_y = y_r;
  assign res_z = z_r;

endmodule

`default_nettype wire

FILE: sv/fixed_point_affine_vector_transform.sv
// Fixed-point affine vector transform: out = R*v / 2^FRAC_BITS + T per vertex.
// Uses fpavt_pkg, fpavt_if, fpavt_lane and fpavt_merge.
//
// Usage:
//   in_vtx carries one signed 16-bit vertex (in_x, in_y, in_z) per beat.
//   out_res carries one wrapped 32-bit result (out_x, out_y, out_z) per beat.
//   cfg_wr_en/cfg_idx/cfg_wdata write the matrix rows (index 0..2, three
//   packed signed 16-bit entries, column 0 lowest) and the translations
//   (index 3..5, low 32 bits); other indexes are ignored. Write only while
//   the pipeline holds no beat.
// An accepted vertex passes these registered stages on its way to out_res:
//   products, row sum, truncating scale, translation add plus output register.
// Throughput is one vertex per cycle unless out_res stalls; each matrix row
//   has its own lane with three 16x16 multipliers, so all rows are worked in
//   the same cycle. A stalled receiver holds the output register; earlier
//   stages keep filling until every stage is full, then in_vtx.ready drops.
// Reset clears all stage valid bits and loads the identity matrix (at
//   FRAC_BITS = 12) and zero translation.
`default_nettype none

module fixed_point_affine_vector_transform #(
  parameter int FRAC_BITS = 12
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  fpavt_in_if.sink                               in_vtx,
  fpavt_out_if.source                            out_res,
  input  wire                                    cfg_wr_en,
  input  wire logic [fpavt_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [fpavt_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  fpavt_pkg::row_t row_r [fpavt_pkg::NUM_LANES];
  logic [fpavt_pkg::NUM_LANES-1:0][fpavt_pkg::RES_W-1:0] trans_r;
  logic [fpavt_pkg::NUM_LANES-1:0][fpavt_pkg::RES_W-1:0] lane_q;

  logic v1_r, v2_r, v3_r, vo_r;
  logic ld1, ld2, ld3, ld4;
  fpavt_pkg::stage_en_t en;
  fpavt_pkg::res_t res_x, res_y, res_z;

  always_comb begin
    ld4   = !vo_r || out_res.ready;
    ld3   = !v3_r || ld4;
    ld2   = !v2_r || ld3;
    ld1   = !v1_r || ld2;
    en.s1 = ld1 && in_vtx.valid;
    en.s2 = ld2 && v1_r;
    en.s3 = ld3 && v2_r;
    en.s4 = ld4 && v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (ld1) v1_r <= in_vtx.valid;
      if (ld2) v2_r <= v1_r;
      if (ld3) v3_r <= v2_r;
      if (ld4) vo_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0]   <= fpavt_pkg::ROW_0_RST;
      row_r[1]   <= fpavt_pkg::ROW_1_RST;
      row_r[2]   <= fpavt_pkg::ROW_2_RST;
      trans_r[0] <= fpavt_pkg::TRANS_RST;
      trans_r[1] <= fpavt_pkg::TRANS_RST;
      trans_r[2] <= fpavt_pkg::TRANS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx)
        fpavt_pkg::REG_ROW_0:   row_r[0]   <= cfg_wdata;
        fpavt_pkg::REG_ROW_1:   row_r[1]   <= cfg_wdata;
        fpavt_pkg::REG_ROW_2:   row_r[2]   <= cfg_wdata;
        fpavt_pkg::REG_TRANS_X: trans_r[0] <= cfg_wdata[fpavt_pkg::RES_W-1:0];
        fpavt_pkg::REG_TRANS_Y: trans_r[1] <= cfg_wdata[fpavt_pkg::RES_W-1:0];
        fpavt_pkg::REG_TRANS_Z: trans_r[2] <= cfg_wdata[fpavt_pkg::RES_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < fpavt_pkg::NUM_LANES; i++) begin : g_lane
    fpavt_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk (clk),
      .en  (en),
      .x   (in_vtx.in_x),
      .y   (in_vtx.in_y),
      .z   (in_vtx.in_z),
      .row (row_r[i]),
      .q   (lane_q[i])
    );
  end

  fpavt_merge u_merge (
    .clk    (clk),
    .en     (en),
    .lane_q (lane_q),
    .trans  (trans_r),
    .res_x  (res_x),
    .res_y  (res_y),
    .res_z  (res_z)
  );

  assign in_vtx.ready  = ld1;
  assign out_res.valid = vo_r;
  assign out_res.out_x = res_x;
  assign out_res.out_y = res_y;
  assign out_res.out_z = res_z;

endmodule

`default_nettype wire

FILE: sv/fpavt_chk.sv
// Port-level checker for the affine vector transform, bound to the top level.
// Depends on fpavt_pkg for result widths.
`default_nettype none

module fpavt_chk (
  input wire                         clk,
  input wire                         rst_n,
  input wire                         in_valid,
  input wire                         in_ready,
  input wire                         out_valid,
  input wire                         out_ready,
  input wire [fpavt_pkg::RES_W-1:0]  out_x,
  input wire [fpavt_pkg::RES_W-1:0]  out_y,
  input wire [fpavt_pkg::RES_W-1:0]  out_z
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_z))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_no_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("vertex stalled while result side is ready");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && out_ready ##1 out_ready ##1 out_ready ##1 out_ready
      |=> out_valid)
    else $error("result missing four cycles after vertex beat");

endmodule

bind fixed_point_affine_vector_transform fpavt_chk u_fpavt_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_vtx.valid),
  .in_ready  (in_vtx.ready),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready),
  .out_x     (out_res.out_x),
  .out_y     (out_res.out_y),
  .out_z     (out_res.out_z)
);

`default_nettype wire

FILE: tb/sv/fixed_point_affine_vector_transform_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for fixed_point_affine_vector_transform: random and directed
// vertex beats under varying stalls, predicted results compared beat by beat.
// Depends on fpavt_pkg, fpavt_if and the transform RTL.

module fixed_point_affine_vector_transform_tb;

  localparam int FRAC_BITS     = 12;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 200000;
  localparam int SET_ITEMS     = 120;

  localparam logic [fpavt_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_6 = 3'd6;
  localparam logic [fpavt_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_7 = 3'd7;

  typedef struct packed {
    logic signed [fpavt_pkg::COORD_W-1:0] x;
    logic signed [fpavt_pkg::COORD_W-1:0] y;
    logic signed [fpavt_pkg::COORD_W-1:0] z;
  } vertex_t;

  typedef struct packed {
    fpavt_pkg::res_t x;
    fpavt_pkg::res_t y;
    fpavt_pkg::res_t z;
  } xform_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [fpavt_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [fpavt_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic hold_req = 1'b0;
  int hold_left;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_cnt = 0;

  fpavt_pkg::row_t mat_row [fpavt_pkg::NUM_LANES];
  fpavt_pkg::res_t offset [fpavt_pkg::NUM_LANES];

  vertex_t vertex_q [$];
  xform_t result_q [$];

  fpavt_in_if in_vtx ();
  fpavt_out_if out_res ();

  fixed_point_affine_vector_transform #(.FRAC_BITS(FRAC_BITS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vtx    (in_vtx),
    .out_res   (out_res),
    .cfg_wr_en (cfg_wr_en),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic fpavt_pkg::res_t lane_result(fpavt_pkg::row_t row, vertex_t v,
                                                  fpavt_pkg::res_t t);
    longint acc;
    longint q;
    acc = longint'(v.x) * longint'($signed(row[15:0]))
        + longint'(v.y) * longint'($signed(row[31:16]))
        + longint'(v.z) * longint'($signed(row[47:32]));
    if (acc < 0) begin
      q = -((-acc) >>> FRAC_BITS);
    end else begin
      q = acc >>> FRAC_BITS;
    end
    return fpavt_pkg::res_t'(q + longint'(t));
  endfunction

  function automatic xform_t transform_vertex(vertex_t v);
    xform_t r;
    r.x = lane_result(mat_row[0], v, offset[0]);
    r.y = lane_result(mat_row[1], v, offset[1]);
    r.z = lane_result(mat_row[2], v, offset[2]);
    return r;
  endfunction

  function automatic vertex_t vtx(int x, int y, int z);
    vertex_t v;
    v.x = fpavt_pkg::COORD_W'(x);
    v.y = fpavt_pkg::COORD_W'(y);
    v.z = fpavt_pkg::COORD_W'(z);
    return v;
  endfunction

  function automatic logic [fpavt_pkg::COORD_W-1:0] pick_coord();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(32)) - 16'd16;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [fpavt_pkg::ENTRY_W-1:0] pick_entry();
    case ($urandom_range(6))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h1000;
      3: return 16'hF000;
      4: return 16'($urandom_range(8192)) - 16'd4096;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic fpavt_pkg::res_t pick_offset();
    case ($urandom_range(4))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(2000)) - 32'd1000;
      default: return 32'($urandom);
    endcase
  endfunction

  // Drive one register write; the pipeline is empty, so update the shadow copy now.
  task automatic write_reg(logic [fpavt_pkg::CFG_IDX_W-1:0] idx,
                           logic [fpavt_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      fpavt_pkg::REG_ROW_0:   mat_row[0] = data;
      fpavt_pkg::REG_ROW_1:   mat_row[1] = data;
      fpavt_pkg::REG_ROW_2:   mat_row[2] = data;
      fpavt_pkg::REG_TRANS_X: offset[0] = data[fpavt_pkg::RES_W-1:0];
      fpavt_pkg::REG_TRANS_Y: offset[1] = data[fpavt_pkg::RES_W-1:0];
      fpavt_pkg::REG_TRANS_Z: offset[2] = data[fpavt_pkg::RES_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    while ((vertex_q.size() != 0 || in_vtx.valid || result_q.size() != 0)
           && guard < DRAIN_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Vertex driver: advance only when the current beat is taken or none is offered.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_vtx.valid <= 1'b0;
    end else if (!in_vtx.valid || in_vtx.ready) begin
      if (vertex_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        vertex_t v;
        v = vertex_q.pop_front();
        in_vtx.valid <= 1'b1;
        in_vtx.in_x  <= v.x;
        in_vtx.in_y  <= v.y;
        in_vtx.in_z  <= v.z;
      end else begin
        in_vtx.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus a long hold on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_res.ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_req) begin
      out_res.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      out_res.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_res.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    xform_t want;
    vertex_t got_in;
    if (rst_n) begin
      if (out_res.valid && out_res.ready) begin
        if (result_q.size() == 0) begin
          $error("result beat with no result expected: x=%0d y=%0d z=%0d",
                 out_res.out_x, out_res.out_y, out_res.out_z);
          mismatch_cnt++;
        end else begin
          want = result_q.pop_front();
          if (out_res.out_x !== want.x) begin
            $error("out_x: expected %0d, got %0d", $signed(want.x), out_res.out_x);
            mismatch_cnt++;
          end
          if (out_res.out_y !== want.y) begin
            $error("out_y: expected %0d, got %0d", $signed(want.y), out_res.out_y);
            mismatch_cnt++;
          end
          if (out_res.out_z !== want.z) begin
            $error("out_z: expected %0d, got %0d", $signed(want.z), out_res.out_z);
            mismatch_cnt++;
          end
        end
      end
      if (in_vtx.valid && in_vtx.ready) begin
        got_in.x = in_vtx.in_x;
        got_in.y = in_vtx.in_y;
        got_in.z = in_vtx.in_z;
        result_q.push_back(transform_vertex(got_in));
      end
    end
  end

  initial begin
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int phase;
    int set_no;
    int k;
    in_vtx.valid  = 1'b0;
    in_vtx.in_x   = '0;
    in_vtx.in_y   = '0;
    in_vtx.in_z   = '0;
    out_res.ready = 1'b0;
    mat_row[0] = fpavt_pkg::ROW_0_RST;
    mat_row[1] = fpavt_pkg::ROW_1_RST;
    mat_row[2] = fpavt_pkg::ROW_2_RST;
    offset[0] = fpavt_pkg::TRANS_RST;
    offset[1] = fpavt_pkg::TRANS_RST;
    offset[2] = fpavt_pkg::TRANS_RST;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Identity matrix out of reset: extremes pass straight through.
    vertex_q.push_back(vtx(0, 0, 0));
    vertex_q.push_back(vtx(32767, 32767, 32767));
    vertex_q.push_back(vtx(-32768, -32768, -32768));
    vertex_q.push_back(vtx(-1, 1, -1));
    vertex_q.push_back(vtx(32767, -32768, 0));
    vertex_q.push_back(vtx(1, -1, 4096));
    wait_drained();

    // Extreme entries, a tiny row for truncation toward zero, wrapping offsets
    // written with extra upper bits, and writes to unmapped indexes.
    write_reg(fpavt_pkg::REG_ROW_0, {16'h8000, 16'h8000, 16'h8000});
    write_reg(fpavt_pkg::REG_ROW_1, {16'h7FFF, 16'h7FFF, 16'h7FFF});
    write_reg(fpavt_pkg::REG_ROW_2, {16'h0001, 16'hFFFF, 16'h0001});
    write_reg(fpavt_pkg::REG_TRANS_X, 48'hABCD_7FFF_FFFF);
    write_reg(fpavt_pkg::REG_TRANS_Y, 48'h1234_8000_0000);
    write_reg(fpavt_pkg::REG_TRANS_Z, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_UNMAPPED_6, 48'h5555_AAAA_5555);
    write_reg(REG_UNMAPPED_7, 48'hFFFF_FFFF_FFFF);
    vertex_q.push_back(vtx(0, 0, 0));
    vertex_q.push_back(vtx(-32768, -32768, -32768));
    vertex_q.push_back(vtx(32767, 32767, 32767));
    vertex_q.push_back(vtx(-32768, 32767, -32768));
    vertex_q.push_back(vtx(-1, 0, 0));
    vertex_q.push_back(vtx(1, 0, 0));
    vertex_q.push_back(vtx(-4097, 0, 0));
    vertex_q.push_back(vtx(0, -1, 0));
    vertex_q.push_back(vtx(0, 0, -1));
    vertex_q.push_back(vtx(4095, 4095, 4095));
    vertex_q.push_back(vtx(-4095, 0, 0));
    vertex_q.push_back(vtx(12345, -23456, 777));
    wait_drained();

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 13;
          recv_stall_pct = 47;
        end
        1: begin
          send_idle_pct = 47;
          recv_stall_pct = 13;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (set_no = 0; set_no < 4; set_no++) begin
        write_reg(fpavt_pkg::REG_ROW_0, {pick_entry(), pick_entry(), pick_entry()});
        write_reg(fpavt_pkg::REG_ROW_1, {pick_entry(), pick_entry(), pick_entry()});
        write_reg(fpavt_pkg::REG_ROW_2, {pick_entry(), pick_entry(), pick_entry()});
        write_reg(fpavt_pkg::REG_TRANS_X, {16'($urandom), pick_offset()});
        write_reg(fpavt_pkg::REG_TRANS_Y, {16'($urandom), pick_offset()});
        write_reg(fpavt_pkg::REG_TRANS_Z, {16'($urandom), pick_offset()});
        if ($urandom_range(1) == 0) begin
          write_reg(($urandom_range(1) == 0) ? REG_UNMAPPED_6 : REG_UNMAPPED_7,
                    {16'($urandom), 32'($urandom)});
        end
        for (k = 0; k < SET_ITEMS; k++) begin
          vertex_q.push_back(vtx(int'($signed(pick_coord())), int'($signed(pick_coord())),
                                 int'($signed(pick_coord()))));
        end
        if (phase == 2 && set_no == 1) begin
          // Hold the receiver while the sender keeps offering beats.
          @(posedge clk);
          hold_req <= 1'b1;
          @(posedge clk);
          hold_req <= 1'b0;
        end
        wait_drained();
      end
    end

    if (result_q.size() != 0) begin
      $error("%0d expected results never arrived", result_q.size());
    end
    if (mismatch_cnt == 0 && result_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: fixed_point_affine_vector_transform.f
sv/fpavt_pkg.sv
sv/fpavt_if.sv
sv/fpavt_lane.sv
sv/fpavt_merge.sv
sv/fixed_point_affine_vector_transform.sv
sv/fpavt_chk.sv
tb/sv/fixed_point_affine_vector_transform_tb.sv
